/* hw/rtl/npcc_pkg.sv */
`default_nettype none

package npcc_pkg;

    localparam int PALETTE_DEPTH_DEFAULT = 256;
    localparam int COUNT_W               = 9;
    localparam int CHAN_W                = 8;
    localparam int ATTR_W                = 8;
    localparam int SQ_W                  = 2 * CHAN_W;
    localparam int DIST_W                = SQ_W + 2;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        rgba_t             color;
    } entry_t;

    // Control that travels with each palette entry down the distance pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

/* hw/rtl/nearest_palette_color_classifier_core.sv */
// Nearest palette color classifier. Load items (command 0) write one palette
// entry, an attribute id and an RGBA color, into an on-chip table and leave the
// block ready; a slot at or beyond PALETTE_DEPTH is dropped. Classify items (command 1)
// scan the first palette_count entries (saturated to PALETTE_DEPTH) in slot
// order through one shared distance pipeline, one entry per cycle, and return
// the attribute of the entry with the smallest squared RGBA distance, lowest
// slot on a tie. A classify item occupies the block while its entries pass
// through the single table read port feeding the distance unit, then the table
// read, the two distance stages and the result hand-off, which waits for a free
// output register; an empty palette returns status 1 with attribute 0. The block
// accepts the next item while a finished result still waits in the output
// register. Write palette_count only while the block is idle.
`default_nettype none

module nearest_palette_color_classifier_core
#(
    parameter int PALETTE_DEPTH = npcc_pkg::PALETTE_DEPTH_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_wr_en,
    input  wire logic [npcc_pkg::COUNT_W-1:0]   cfg_wr_data,

    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic                           command,
    input  wire logic [7:0]                     entry_index,
    input  wire logic [npcc_pkg::ATTR_W-1:0]    entry_attribute,
    input  wire logic [npcc_pkg::CHAN_W-1:0]    red,
    input  wire logic [npcc_pkg::CHAN_W-1:0]    green,
    input  wire logic [npcc_pkg::CHAN_W-1:0]    blue,
    input  wire logic [npcc_pkg::CHAN_W-1:0]    alpha,

    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic [npcc_pkg::ATTR_W-1:0]         attribute,
    output logic                                status
);

    localparam int CNT_W  = npcc_pkg::COUNT_W;
    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int IDX_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int DW     = npcc_pkg::DIST_W;
    localparam int AW     = npcc_pkg::ATTR_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     palette_count_reg;
    logic [IDX_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    npcc_pkg::rgba_t      pixel_reg, pixel_next;
    logic                 first_reg, first_next;
    logic [DW-1:0]        best_dist_reg, best_dist_next;
    logic [AW-1:0]        best_attr_reg, best_attr_next;
    logic                 empty_reg, empty_next;

    logic                 result_valid_reg, result_valid_next;
    logic [AW-1:0]        result_attr_reg, result_attr_next;
    logic                 result_status_reg, result_status_next;

    npcc_pkg::entry_t     palette_mem [PALETTE_DEPTH];
    npcc_pkg::entry_t     rd_data_reg;
    npcc_pkg::tag_t       rd_tag_reg, rd_tag_next;

    npcc_pkg::tag_t       d_tag;
    logic [DW-1:0]        d_dist;
    logic [AW-1:0]        d_attr;

    logic                 item_xfer;
    logic                 mem_we;
    logic [CNT_W-1:0]     count_sat;
    logic [IDX_W-1:0]     rd_idx_inc;
    npcc_pkg::entry_t     wr_entry;
    npcc_pkg::rgba_t      in_pixel;

    assign item_ready = (state_reg == S_IDLE);
    assign item_xfer  = item_valid && item_ready;
    assign mem_we     = item_xfer && (command == npcc_pkg::CMD_LOAD)
                        && (CNT_W'(entry_index) < CNT_W'(PALETTE_DEPTH));

    assign in_pixel.red   = red;
    assign in_pixel.green = green;
    assign in_pixel.blue  = blue;
    assign in_pixel.alpha = alpha;
    assign wr_entry.attr  = entry_attribute;
    assign wr_entry.color = in_pixel;

    assign count_sat  = (palette_count_reg > CNT_W'(PALETTE_DEPTH))
                        ? CNT_W'(PALETTE_DEPTH) : palette_count_reg;
    assign rd_idx_inc = rd_idx_reg + IDX_W'(1);

    // Palette table: one write port for loads, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[entry_index[ADDR_W-1:0]] <= wr_entry;
        end
        rd_data_reg <= palette_mem[rd_idx_reg[ADDR_W-1:0]];
    end

    npcc_dist u_dist
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry_tag  (rd_tag_reg),
        .entry      (rd_data_reg),
        .pixel      (pixel_reg),
        .dist_tag   (d_tag),
        .dist_value (d_dist),
        .dist_attr  (d_attr)
    );

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        rd_idx_next        = rd_idx_reg;
        pixel_next         = pixel_reg;
        first_next         = first_reg;
        best_dist_next     = best_dist_reg;
        best_attr_next     = best_attr_reg;
        empty_next         = empty_reg;
        rd_tag_next        = '0;
        result_valid_next  = result_valid_reg;
        result_attr_next   = result_attr_reg;
        result_status_next = result_status_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        // Keep the running minimum; strict less-than keeps the lowest slot on a tie
        if (d_tag.valid)
        begin
            first_next = 1'b0;
            if (first_reg || (d_dist < best_dist_reg))
            begin
                best_dist_next = d_dist;
                best_attr_next = d_attr;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer && (command == npcc_pkg::CMD_CLASSIFY))
                begin
                    pixel_next  = in_pixel;
                    count_next  = count_sat[IDX_W-1:0];
                    rd_idx_next = '0;
                    first_next  = 1'b1;
                    if (count_sat == '0)
                    begin
                        empty_next     = 1'b1;
                        best_attr_next = '0;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        empty_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_tag_next.valid = 1'b1;
                rd_tag_next.last  = (rd_idx_inc == count_reg);
                rd_idx_next       = rd_idx_inc;
                if (rd_idx_inc == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (d_tag.valid && d_tag.last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next  = 1'b1;
                    result_attr_next   = best_attr_reg;
                    result_status_next = empty_reg ? npcc_pkg::STATUS_EMPTY
                                                   : npcc_pkg::STATUS_OK;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            palette_count_reg <= '0;
            result_valid_reg  <= 1'b0;
            rd_tag_reg        <= '0;
            first_reg         <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            rd_tag_reg       <= rd_tag_next;
            first_reg        <= first_next;
            if (cfg_wr_en)
            begin
                palette_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg         <= count_next;
        rd_idx_reg        <= rd_idx_next;
        pixel_reg         <= pixel_next;
        best_dist_reg     <= best_dist_next;
        best_attr_reg     <= best_attr_next;
        empty_reg         <= empty_next;
        result_attr_reg   <= result_attr_next;
        result_status_reg <= result_status_next;
    end

    assign result_valid = result_valid_reg;
    assign attribute    = result_attr_reg;
    assign status       = result_status_reg;

endmodule

`default_nettype wire

/* hw/rtl/npcc_dist.sv */
`default_nettype none

module npcc_dist
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire npcc_pkg::tag_t                entry_tag,
    input  wire npcc_pkg::entry_t              entry,
    input  wire npcc_pkg::rgba_t               pixel,
    output npcc_pkg::tag_t                     dist_tag,
    output logic [npcc_pkg::DIST_W-1:0]        dist_value,
    output logic [npcc_pkg::ATTR_W-1:0]        dist_attr
);

    localparam int CW = npcc_pkg::CHAN_W;
    localparam int SW = npcc_pkg::SQ_W;
    localparam int DW = npcc_pkg::DIST_W;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    npcc_pkg::tag_t             sq_tag_reg;
    logic [SW-1:0]              sq_reg [4];
    logic [npcc_pkg::ATTR_W-1:0] sq_attr_reg;

    npcc_pkg::tag_t             sum_tag_reg;
    logic [DW-1:0]              sum_reg;
    logic [npcc_pkg::ATTR_W-1:0] sum_attr_reg;

    logic [CW-1:0] diff [4];
    logic [DW-1:0] sum_next;

    always_comb
    begin
        diff[0] = abs_diff(entry.color.red,   pixel.red);
        diff[1] = abs_diff(entry.color.green, pixel.green);
        diff[2] = abs_diff(entry.color.blue,  pixel.blue);
        diff[3] = abs_diff(entry.color.alpha, pixel.alpha);
        sum_next = DW'(sq_reg[0]) + DW'(sq_reg[1]) + DW'(sq_reg[2]) + DW'(sq_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_tag_reg  <= '0;
            sum_tag_reg <= '0;
        end
        else
        begin
            sq_tag_reg  <= entry_tag;
            sum_tag_reg <= sq_tag_reg;
        end
    end

    // Square the channel differences, then add the four squares
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            sq_reg[k] <= SW'(diff[k]) * SW'(diff[k]);
        end
        sq_attr_reg  <= entry.attr;
        sum_reg      <= sum_next;
        sum_attr_reg <= sq_attr_reg;
    end

    assign dist_tag   = sum_tag_reg;
    assign dist_value = sum_reg;
    assign dist_attr  = sum_attr_reg;

endmodule

`default_nettype wire

/* hw/rtl/npcc_checker.sv */
`default_nettype none

module npcc_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_ready,
    input wire logic                          command,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [npcc_pkg::ATTR_W-1:0]   attribute,
    input wire logic                          status
);

    // A stalled result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(attribute) && $stable(status))
        else $error("result payload changed while stalled");

    // An empty-palette result carries attribute zero
    a_empty_attr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == npcc_pkg::STATUS_EMPTY) |-> (attribute == '0))
        else $error("empty status with nonzero attribute");

    // A classify transfer keeps the block busy on the next cycle
    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (command == npcc_pkg::CMD_CLASSIFY) |=> !item_ready)
        else $error("block ready right after classify transfer");

    // A load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (command == npcc_pkg::CMD_LOAD) && !result_valid
        |=> !result_valid)
        else $error("result appeared after a load");

endmodule

bind nearest_palette_color_classifier_core npcc_checker u_npcc_checker (.*);

`default_nettype wire
